// ----- sv/swrm_pkg.sv -----
// Shared constants for the sliding window rate monitor.
// Field widths, register indexes and reset values; no dependencies.
`default_nettype none

package swrm_pkg;

   localparam int KIND_W     = 1;
   localparam int TIME_NS_W  = 63;
   localparam int RATE_W     = 48;
   localparam int WIN_SIZE_W = 7;
   localparam int TIMEOUT_W  = 40;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 40;
   localparam int DIVISOR_W  = 64;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_STAMP = 1'b0;
   localparam logic [KIND_W-1:0] KIND_CHECK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_NS  = 8'd1;

   localparam int                   MIN_WINDOW    = 4;
   localparam int                   NS_PER_SEC_W  = 30;
   localparam logic [29:0]          NS_PER_SEC    = 30'd1000000000;
   localparam logic [RATE_W-1:0]    RATE_MAX      = {RATE_W{1'b1}};
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 40'd500000000;

endpackage

`default_nettype wire

// ----- sv/swrm_if.sv -----
// Valid/ready channel interfaces for the rate monitor: request, response, CSR write.
// Depends on swrm_pkg for field widths.
`default_nettype none

interface swrm_req_if;
   import swrm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [TIME_NS_W-1:0] time_ns;
   modport source (output valid, kind, time_ns, input ready);
   modport sink   (input valid, kind, time_ns, output ready);
endinterface

interface swrm_rsp_if;
   import swrm_pkg::*;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] rate_hz_q16;
   logic              timed_out;
   modport source (output valid, rate_hz_q16, timed_out, input ready);
   modport sink   (input valid, rate_hz_q16, timed_out, output ready);
endinterface

interface swrm_csr_if;
   import swrm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/sliding_window_rate_monitor.sv -----
// Sliding window rate monitor: period ring in a synchronous RAM, running sum,
// restoring divider for 1e9*W*2^16/sum. Depends on swrm_pkg and swrm_if.
//
//   channel   dir  payload                      transfer when
//   req_chan  in   kind, time_ns                valid & ready
//   rsp_chan  out  rate_hz_q16, timed_out       valid & ready
//   csr_chan  in   index, data                  valid & ready
//
// One item at a time. A check passes DIFF, DONE; a timestamp while the window fills
// passes DIFF, SUM, DONE; a full-window timestamp with a zero sum passes DIFF, SUM,
// DIVINIT, DONE; others pass DIFF, SUM, DIVINIT, DIV (one quotient bit per cycle),
// ROUND, SAT, DONE. The next request can transfer in the cycle the result appears.
// A waiting result sits in the output register; the next request is taken meanwhile.
// CSR writes are taken only while idle, ahead of a request in the same cycle.
// Reset is synchronous; the ring needs no clearing pass.
`default_nettype none

module sliding_window_rate_monitor #(
   parameter int MAX_WINDOW = 64,
   parameter int TIME_WIDTH = 63
) (
   input  wire logic   clock,
   input  wire logic   reset,
   swrm_req_if.sink    req_chan,
   swrm_rsp_if.source  rsp_chan,
   swrm_csr_if.sink    csr_chan
);
   import swrm_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WINDOW);
   localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = TIME_WIDTH + ADDR_W;
   localparam int SUMX_W = (SUM_W > DIVISOR_W + 1) ? SUM_W : DIVISOR_W + 1;
   localparam int PROD_W = NS_PER_SEC_W + WIN_W;
   localparam int NUM_W  = PROD_W + 16;
   localparam int STEP_W = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIFF, ST_SUM, ST_DIVINIT, ST_DIV, ST_ROUND, ST_SAT, ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [TIME_WIDTH-1:0]    time_ff, time_in;
   logic [TIME_WIDTH-1:0]    last_ff, last_in;
   logic [TIME_WIDTH-1:0]    period_ff, period_in;
   logic [ADDR_W-1:0]        head_ff, head_in;
   logic [WIN_W-1:0]         count_ff, count_in;
   logic [WIN_W-1:0]         win_ff, win_in;
   logic [TIMEOUT_W-1:0]     timeout_ff, timeout_in;
   logic [SUMX_W-1:0]        sum_ff, sum_in;
   logic                     full_ff, full_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic                     flag_ff, flag_in;
   logic [DIVISOR_W-1:0]     div_d_ff, div_d_in;
   logic [DIVISOR_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]        rsp_rate_ff, rsp_rate_in;
   logic                     rsp_flag_ff, rsp_flag_in;

   logic [TIME_WIDTH-1:0]    period_ring_ff [MAX_WINDOW];
   logic [TIME_WIDTH-1:0]    ring_rd_ff;
   logic                     mem_we, mem_re;
   logic [ADDR_W-1:0]        rd_addr;

   logic                     req_xfer, csr_xfer;
   logic [TIME_WIDTH:0]      diff_ext;
   logic [TIME_WIDTH-1:0]    period_val;
   logic [WIN_W-1:0]         win_new;
   logic [DIVISOR_W-1:0]     sum_sat;
   logic [PROD_W-1:0]        num_base;
   logic [DIVISOR_W:0]       div_shift;
   logic [DIVISOR_W+1:0]     div_trial;
   logic                     round_up;
   logic [WIN_W:0]           head_ext, win_ext;

   function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_SIZE_W-1:0] ws);
      logic [WIN_W-1:0] w;
      if (int'(ws) < MIN_WINDOW) begin
         w = WIN_W'(MIN_WINDOW);
      end else if (int'(ws) > MAX_WINDOW) begin
         w = WIN_W'(MAX_WINDOW);
      end else begin
         w = WIN_W'(ws);
      end
      return w;
   endfunction

   assign csr_chan.ready = (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE) && !csr_chan.valid;
   assign csr_xfer = csr_chan.valid && csr_chan.ready;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.rate_hz_q16 = rsp_rate_ff;
   assign rsp_chan.timed_out   = rsp_flag_ff;

   // oldest slot of a full window: head - W modulo the ring depth
   assign head_ext = (WIN_W + 1)'(head_ff);
   assign win_ext  = (WIN_W + 1)'(win_ff);
   assign rd_addr  = (head_ext >= win_ext) ? ADDR_W'(head_ext - win_ext)
                   : ADDR_W'(head_ext + (WIN_W + 1)'(MAX_WINDOW) - win_ext);

   // time going backward counts as zero
   assign diff_ext   = {1'b0, time_ff} - {1'b0, last_ff};
   assign period_val = diff_ext[TIME_WIDTH] ? '0 : diff_ext[TIME_WIDTH-1:0];

   assign win_new  = clamp_window(csr_chan.data[WIN_SIZE_W-1:0]);
   assign sum_sat  = (|sum_ff[SUMX_W-1:DIVISOR_W]) ? {DIVISOR_W{1'b1}}
                   : sum_ff[DIVISOR_W-1:0];
   assign num_base = PROD_W'(NS_PER_SEC) * PROD_W'(win_ff);

   assign div_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign div_trial = {1'b0, div_shift} - {2'b00, div_d_ff};
   assign round_up  = ({rem_ff, 1'b0} >= {1'b0, div_d_ff});

   assign mem_re = req_xfer;
   assign mem_we = (state_ff == ST_DIFF) && (kind_ff == KIND_STAMP);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      time_in      = time_ff;
      last_in      = last_ff;
      period_in    = period_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      win_in       = win_ff;
      timeout_in   = timeout_ff;
      sum_in       = sum_ff;
      full_in      = full_ff;
      rate_in      = rate_ff;
      flag_in      = flag_ff;
      div_d_in     = div_d_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_rate_in  = rsp_rate_ff;
      rsp_flag_in  = rsp_flag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_xfer) begin
               if (csr_chan.index == CSR_WINDOW_SIZE) begin
                  win_in = win_new;
                  if (win_new != win_ff) begin
                     head_in  = '0;
                     count_in = '0;
                     sum_in   = '0;
                  end
               end else if (csr_chan.index == CSR_TIMEOUT_NS) begin
                  timeout_in = csr_chan.data[TIMEOUT_W-1:0];
               end
            end
            if (req_xfer) begin
               kind_in  = req_chan.kind;
               time_in  = req_chan.time_ns[TIME_WIDTH-1:0];
               flag_in  = 1'b0;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            if (kind_ff == KIND_CHECK) begin
               if (count_ff != '0 && DIVISOR_W'(period_val) > DIVISOR_W'(timeout_ff)) begin
                  rate_in = '0;
                  flag_in = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               head_in   = (int'(head_ff) == MAX_WINDOW - 1) ? '0 : head_ff + 1'b1;
               last_in   = time_ff;
               period_in = period_val;
               full_in   = (count_ff == win_ff);
               if (count_ff == win_ff) begin
                  sum_in = sum_ff - SUMX_W'(ring_rd_ff);
               end else begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            sum_in   = sum_ff + SUMX_W'(period_ff);
            state_in = full_ff ? ST_DIVINIT : ST_DONE;
         end
         ST_DIVINIT: begin
            div_d_in = sum_sat;
            if (sum_sat == '0) begin
               rate_in  = RATE_MAX;
               state_in = ST_DONE;
            end else begin
               quo_in   = {num_base, 16'h0000};
               rem_in   = '0;
               step_in  = STEP_W'(NUM_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_trial[DIVISOR_W+1] ? div_shift[DIVISOR_W-1:0]
                    : div_trial[DIVISOR_W-1:0];
            quo_in  = {quo_ff[NUM_W-2:0], ~div_trial[DIVISOR_W+1]};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // halves round up
            quo_in   = quo_ff + NUM_W'(round_up);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            rate_in  = (|quo_ff[NUM_W-1:RATE_W]) ? RATE_MAX : quo_ff[RATE_W-1:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rate_in  = rate_ff;
               rsp_flag_in  = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         win_ff       <= WIN_W'(MIN_WINDOW);
         timeout_ff   <= TIMEOUT_RESET;
         sum_ff       <= '0;
         rate_ff      <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         win_ff       <= win_in;
         timeout_ff   <= timeout_in;
         sum_ff       <= sum_in;
         rate_ff      <= rate_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      time_ff     <= time_in;
      period_ff   <= period_in;
      full_ff     <= full_in;
      div_d_ff    <= div_d_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_rate_ff <= rsp_rate_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   // period ring; read of the oldest slot happens before the write of the same slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         period_ring_ff[head_ff] <= period_val;
      end
      if (mem_re) begin
         ring_rd_ff <= period_ring_ff[rd_addr];
      end
   end

   a_count_le_window: assert property (@(posedge clock) disable iff (reset)
      count_ff <= win_ff)
      else $error("period count above window size");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(head_ff) < MAX_WINDOW)
      else $error("ring head out of range");

   a_check_keeps_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF && kind_ff == KIND_CHECK)
      |=> ($stable(count_ff) && $stable(head_ff) && $stable(sum_ff)))
      else $error("check item changed the window");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_d_ff != '0))
      else $error("divider running on zero sum");

   a_timeout_zero_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flag_ff) |-> (rsp_rate_ff == '0))
      else $error("timeout flagged with nonzero rate");

endmodule

`default_nettype wire
